@@ hdl/tpi_pkg.sv @@
// Shared widths, lane codes and word types for the triangle plane interpolator.
package tpi_pkg;

    localparam int CW    = 32;              // coordinate width
    localparam int FRAC  = 16;              // fraction bits
    localparam int P_W   = 2 * CW;          // vertex product
    localparam int A_W   = 2 * CW + 1;      // edge cofactor a
    localparam int E_W   = CW + 1;          // edge deltas b, c
    localparam int DEN_W = 2 * CW + 3;      // twice the area
    localparam int G_W   = 2 * CW + 3;      // gradient numerators
    localparam int NUM_W = 3 * CW + 5;      // widest numerator
    localparam int QB_W  = CW + 1;          // quotient bits per lane
    localparam int QM_W  = QB_W + 1;        // quotient after rounding
    localparam int LANES = 3;

    localparam int LANE_Z  = 0;
    localparam int LANE_GX = 1;
    localparam int LANE_GY = 2;

    localparam logic [QM_W-1:0] LIM_NEG = QM_W'(1) << (CW - 1);
    localparam logic [QM_W-1:0] LIM_POS = LIM_NEG - QM_W'(1);

    typedef struct packed {
        logic signed [CW-1:0] v0_x;
        logic signed [CW-1:0] v0_y;
        logic signed [CW-1:0] v0_z;
        logic signed [CW-1:0] v1_x;
        logic signed [CW-1:0] v1_y;
        logic signed [CW-1:0] v1_z;
        logic signed [CW-1:0] v2_x;
        logic signed [CW-1:0] v2_y;
        logic signed [CW-1:0] v2_z;
        logic signed [CW-1:0] query_x;
        logic signed [CW-1:0] query_y;
    } t_in;

    typedef struct packed {
        logic [NUM_W-1:0]                  d;
        logic [LANES-1:0][NUM_W-1:0]       rem;
        logic [LANES-1:0][QB_W-1:0]        q;
        logic [LANES-1:0]                  neg;
        logic [LANES-1:0]                  over;
        logic                              degen;
    } t_div;

    typedef struct packed {
        logic [CW-1:0] interp_z;
        logic [CW-1:0] grad_x;
        logic [CW-1:0] grad_y;
        logic          degenerate;
        logic          saturated;
    } t_res;

endpackage

@@ hdl/tpi_front.sv @@
// Front pipeline: cofactors, area, numerators, magnitudes and divider setup.
module tpi_front import tpi_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_in  i_in,
    output logic o_valid,
    output t_div o_div
);

    logic signed [CW-1:0] w_x [LANES];
    logic signed [CW-1:0] w_y [LANES];
    logic signed [CW-1:0] w_z [LANES];

    assign w_x[0] = i_in.v0_x;
    assign w_y[0] = i_in.v0_y;
    assign w_z[0] = i_in.v0_z;
    assign w_x[1] = i_in.v1_x;
    assign w_y[1] = i_in.v1_y;
    assign w_z[1] = i_in.v1_z;
    assign w_x[2] = i_in.v2_x;
    assign w_y[2] = i_in.v2_y;
    assign w_z[2] = i_in.v2_z;

    logic [6:0] r_vld;

    // stage 1/2 per vertex
    logic signed [P_W-1:0]   r_pj  [LANES];
    logic signed [P_W-1:0]   r_pk  [LANES];
    logic signed [E_W-1:0]   r_b   [LANES];
    logic signed [E_W-1:0]   r_c   [LANES];
    logic signed [CW-1:0]    r_z1  [LANES];
    logic signed [A_W-1:0]   r_a   [LANES];
    logic signed [A_W-1:0]   r_gxp [LANES];
    logic signed [A_W-1:0]   r_gyp [LANES];
    logic signed [CW-1:0]    r_z2  [LANES];

    logic signed [CW-1:0] r_qx1, r_qy1, r_qx2, r_qy2, r_qx3, r_qy3;

    // stage 3
    logic signed [DEN_W-1:0] r_ar2_3;
    logic signed [G_W-1:0]   r_gxn3, r_gyn3;
    logic signed [A_W-1:0]   r_azl [LANES];
    logic signed [A_W-1:0]   r_azh [LANES];

    // stage 4
    logic signed [NUM_W-1:0] r_za;
    logic signed [A_W-1:0]   r_gxlq, r_gylq;
    logic signed [G_W-1:0]   r_gxhq, r_gyhq;
    logic signed [G_W-1:0]   r_gxn4, r_gyn4;
    logic signed [DEN_W-1:0] r_ar2_4;

    // stage 5
    logic signed [NUM_W-1:0] r_num [LANES];
    logic signed [DEN_W-1:0] r_ar2_5;

    // stage 6
    logic [NUM_W-1:0]        r_nm [LANES];
    logic [NUM_W-1:0]        r_dm;
    logic [LANES-1:0]        r_neg6;
    logic                    r_degen6;

    logic signed [NUM_W-1:0] w_ar2_ext;
    logic [NUM_W-1:0]        w_d0;

    genvar gi;
    generate
        for (gi = 0; gi < LANES; gi++) begin : g_vtx
            localparam int J = (gi + 1) % LANES;
            localparam int K = (gi + 2) % LANES;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_pj[gi]  <= w_x[J] * w_y[K];
                    r_pk[gi]  <= w_x[K] * w_y[J];
                    r_b[gi]   <= w_y[J] - w_y[K];
                    r_c[gi]   <= w_x[K] - w_x[J];
                    r_z1[gi]  <= w_z[gi];
                    r_a[gi]   <= r_pj[gi] - r_pk[gi];
                    r_gxp[gi] <= r_b[gi] * r_z1[gi];
                    r_gyp[gi] <= r_c[gi] * r_z1[gi];
                    r_z2[gi]  <= r_z1[gi];
                end
            end
        end
    endgenerate

    assign w_ar2_ext = NUM_W'(r_ar2_5);
    assign w_d0      = r_dm << QB_W;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[5:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_qx1 <= i_in.query_x;
            r_qy1 <= i_in.query_y;
            r_qx2 <= r_qx1;
            r_qy2 <= r_qy1;
            r_qx3 <= r_qx2;
            r_qy3 <= r_qy2;

            // stage 3: area, gradient sums, a*z split at CW bits
            r_ar2_3 <= DEN_W'(r_a[0]) + DEN_W'(r_a[1]) + DEN_W'(r_a[2]);
            r_gxn3  <= G_W'(r_gxp[0]) + G_W'(r_gxp[1]) + G_W'(r_gxp[2]);
            r_gyn3  <= G_W'(r_gyp[0]) + G_W'(r_gyp[1]) + G_W'(r_gyp[2]);
            for (int l = 0; l < LANES; l++) begin
                r_azl[l] <= $signed({1'b0, r_a[l][CW-1:0]}) * r_z2[l];
                r_azh[l] <= $signed(r_a[l][A_W-1:CW]) * r_z2[l];
            end

            // stage 4
            r_za <= (NUM_W'(r_azh[0]) <<< CW) + NUM_W'(r_azl[0])
                  + (NUM_W'(r_azh[1]) <<< CW) + NUM_W'(r_azl[1])
                  + (NUM_W'(r_azh[2]) <<< CW) + NUM_W'(r_azl[2]);
            r_gxlq  <= $signed({1'b0, r_gxn3[CW-1:0]}) * r_qx3;
            r_gxhq  <= $signed(r_gxn3[G_W-1:CW]) * r_qx3;
            r_gylq  <= $signed({1'b0, r_gyn3[CW-1:0]}) * r_qy3;
            r_gyhq  <= $signed(r_gyn3[G_W-1:CW]) * r_qy3;
            r_gxn4  <= r_gxn3;
            r_gyn4  <= r_gyn3;
            r_ar2_4 <= r_ar2_3;

            // stage 5: full numerators
            r_num[LANE_Z]  <= r_za + (NUM_W'(r_gxhq) <<< CW) + NUM_W'(r_gxlq)
                            + (NUM_W'(r_gyhq) <<< CW) + NUM_W'(r_gylq);
            r_num[LANE_GX] <= NUM_W'(r_gxn4) <<< FRAC;
            r_num[LANE_GY] <= NUM_W'(r_gyn4) <<< FRAC;
            r_ar2_5        <= r_ar2_4;

            // stage 6: sign and magnitude
            for (int l = 0; l < LANES; l++) begin
                r_nm[l]   <= r_num[l][NUM_W-1] ? NUM_W'(-r_num[l]) : NUM_W'(r_num[l]);
                r_neg6[l] <= r_num[l][NUM_W-1] ^ r_ar2_5[DEN_W-1];
            end
            r_dm     <= w_ar2_ext[NUM_W-1] ? NUM_W'(-w_ar2_ext) : NUM_W'(w_ar2_ext);
            r_degen6 <= (r_ar2_5 == '0);

            // stage 7: quotient beyond QB_W bits means clip
            o_div.d     <= w_d0;
            o_div.neg   <= r_neg6;
            o_div.degen <= r_degen6;
            for (int l = 0; l < LANES; l++) begin
                o_div.rem[l]  <= r_nm[l];
                o_div.q[l]    <= '0;
                o_div.over[l] <= (r_nm[l] >= w_d0);
            end
        end
    end

    assign o_valid = r_vld[6];

endmodule

@@ hdl/tpi_div_cell.sv @@
// One restoring-division cell: one quotient bit for each of the three lanes.
module tpi_div_cell import tpi_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_div i_div,
    output logic o_valid,
    output t_div o_div
);

    logic [NUM_W-1:0] w_dd;
    logic [LANES-1:0] w_ge;
    t_div             n_div;

    // divisor walks down one place per cell; last cell sees the plain divisor
    assign w_dd = i_div.d >> 1;

    always_comb begin
        n_div   = i_div;
        n_div.d = w_dd;
        for (int l = 0; l < LANES; l++) begin
            w_ge[l]       = (i_div.rem[l] >= w_dd);
            n_div.rem[l]  = w_ge[l] ? (i_div.rem[l] - w_dd) : i_div.rem[l];
            n_div.q[l]    = {i_div.q[l][QB_W-2:0], w_ge[l]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_div <= n_div;
        end
    end

endmodule

@@ hdl/tpi_round.sv @@
// Round to nearest (ties away), clip to range, apply sign and zero-area rule.
module tpi_round import tpi_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_div i_div,
    output logic o_valid,
    output t_res o_res
);

    logic                          r_vld1;
    logic [LANES-1:0][QM_W-1:0]    r_m;
    logic [LANES-1:0]              r_neg;
    logic [LANES-1:0]              r_over;
    logic                          r_degen;

    logic [LANES-1:0][QM_W-1:0]    w_lim;
    logic [LANES-1:0]              w_sat;
    logic [LANES-1:0][QM_W-1:0]    w_val;
    logic [LANES-1:0][QM_W-1:0]    w_sgn;
    t_res                          n_res;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_lim[l] = r_neg[l] ? LIM_NEG : LIM_POS;
            w_sat[l] = r_over[l] || (r_m[l] > w_lim[l]);
            w_val[l] = w_sat[l] ? w_lim[l] : r_m[l];
            w_sgn[l] = r_neg[l] ? (QM_W'(0) - w_val[l]) : w_val[l];
        end
        n_res.interp_z   = r_degen ? '0 : w_sgn[LANE_Z][CW-1:0];
        n_res.grad_x     = r_degen ? '0 : w_sgn[LANE_GX][CW-1:0];
        n_res.grad_y     = r_degen ? '0 : w_sgn[LANE_GY][CW-1:0];
        n_res.degenerate = r_degen;
        n_res.saturated  = !r_degen && (|w_sat);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1  <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_vld1  <= i_valid;
            o_valid <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < LANES; l++) begin
                // twice the remainder against the divisor decides the round-up
                r_m[l] <= QM_W'(i_div.q[l])
                        + QM_W'({i_div.rem[l], 1'b0} >= {1'b0, i_div.d});
            end
            r_neg   <= i_div.neg;
            r_over  <= i_div.over;
            r_degen <= i_div.degen;
            o_res   <= n_res;
        end
    end

endmodule

@@ hdl/triangle_plane_interpolator.sv @@
// Top level: front pipeline, divider cell chain, rounding and output skid.
//
//  channel | valid       | ready        | word
//  --------+-------------+--------------+-----------------------------------
//  in      | i_in_valid  | o_in_ready   | i_v0_x .. i_query_y, Q16.16
//  out     | o_out_valid | i_out_ready  | o_interp_z, o_grad_x, o_grad_y,
//          |             |              | o_degenerate, o_saturated
//
// One word per cycle sustained while the output is not stalled. The path runs through
// 7 front stages, one divider cell per quotient bit (CW + 1), 2 rounding
// stages and the output register.
// Reset clears only valid bits; no clearing pass.
// A result arriving while the output register is stalled parks in a skid register; the pipeline then holds
// until the output register drains it.
module triangle_plane_interpolator import tpi_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [CW-1:0] i_v0_x,
    input  logic [CW-1:0] i_v0_y,
    input  logic [CW-1:0] i_v0_z,
    input  logic [CW-1:0] i_v1_x,
    input  logic [CW-1:0] i_v1_y,
    input  logic [CW-1:0] i_v1_z,
    input  logic [CW-1:0] i_v2_x,
    input  logic [CW-1:0] i_v2_y,
    input  logic [CW-1:0] i_v2_z,
    input  logic [CW-1:0] i_query_x,
    input  logic [CW-1:0] i_query_y,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [CW-1:0] o_interp_z,
    output logic [CW-1:0] o_grad_x,
    output logic [CW-1:0] o_grad_y,
    output logic          o_degenerate,
    output logic          o_saturated
);

    t_in  w_in;
    logic w_en;

    logic w_vld [QB_W+1];
    t_div w_div [QB_W+1];

    logic w_res_vld;
    t_res w_res;

    logic r_out_valid;
    t_res r_out;
    logic r_skid_valid;
    t_res r_skid;

    assign w_in.v0_x    = i_v0_x;
    assign w_in.v0_y    = i_v0_y;
    assign w_in.v0_z    = i_v0_z;
    assign w_in.v1_x    = i_v1_x;
    assign w_in.v1_y    = i_v1_y;
    assign w_in.v1_z    = i_v1_z;
    assign w_in.v2_x    = i_v2_x;
    assign w_in.v2_y    = i_v2_y;
    assign w_in.v2_z    = i_v2_z;
    assign w_in.query_x = i_query_x;
    assign w_in.query_y = i_query_y;

    assign w_en       = !r_skid_valid;
    assign o_in_ready = w_en;

    tpi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_in    (w_in),
        .o_valid (w_vld[0]),
        .o_div   (w_div[0])
    );

    genvar gc;
    generate
        for (gc = 0; gc < QB_W; gc++) begin : g_cell
            tpi_div_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en),
                .i_valid (w_vld[gc]),
                .i_div   (w_div[gc]),
                .o_valid (w_vld[gc+1]),
                .o_div   (w_div[gc+1])
            );
        end
    endgenerate

    tpi_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_vld[QB_W]),
        .i_div   (w_div[QB_W]),
        .o_valid (w_res_vld),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_out_valid && !i_out_ready) begin
            if (w_en && w_res_vld) begin
                r_skid_valid <= 1'b1;
            end
        end else if (r_skid_valid) begin
            r_out_valid  <= 1'b1;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid <= w_res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_out_valid && !i_out_ready) begin
            if (w_en) begin
                r_skid <= w_res;
            end
        end else if (r_skid_valid) begin
            r_out <= r_skid;
        end else begin
            r_out <= w_res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_interp_z   = r_out.interp_z;
    assign o_grad_x     = r_out.grad_x;
    assign o_grad_y     = r_out.grad_y;
    assign o_degenerate = r_out.degenerate;
    assign o_saturated  = r_out.saturated;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word without output word");

    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |=> (o_in_ready || r_out_valid))
        else $error("input stalled with empty output");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_out_ready) |=> !r_skid_valid)
        else $error("skid word not drained");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_degenerate) |->
            (o_interp_z == '0 && o_grad_x == '0 && o_grad_y == '0 && !o_saturated))
        else $error("zero-area word carries data");

endmodule

@@ verif/tb_top.sv @@
// Testbench for the triangle plane interpolator: random and directed words, scoreboard check.
module tb_top import tpi_pkg::*; ();

    localparam int LATENCY   = CW + 11;
    localparam int WDOG_MAX  = 20000;
    localparam int N_RANDOM  = 850;
    localparam int HOLD_LEN  = 300;

    typedef enum int {PH_SEND_IDLE, PH_RECV_IDLE, PH_NO_IDLE} t_phase;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic [CW-1:0] i_v0_x = '0, i_v0_y = '0, i_v0_z = '0;
    logic [CW-1:0] i_v1_x = '0, i_v1_y = '0, i_v1_z = '0;
    logic [CW-1:0] i_v2_x = '0, i_v2_y = '0, i_v2_z = '0;
    logic [CW-1:0] i_query_x = '0, i_query_y = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic [CW-1:0] o_interp_z, o_grad_x, o_grad_y;
    logic o_degenerate, o_saturated;

    t_in  tri_queue[$];
    t_res plane_queue[$];
    t_phase phase = PH_SEND_IDLE;
    int   n_errors = 0;
    int   n_checked = 0;
    int   n_sent = 0;
    int   n_degen = 0;
    int   n_sat = 0;
    int   idle_cnt = 0;
    bit   sender_hold = 1'b0;
    bit   recv_hold_req = 1'b0;
    int   recv_hold_cnt = 0;

    triangle_plane_interpolator dut (.*);

    always #10 i_clk = ~i_clk;

    // Rounded quotient, ties away from zero, clipped to CW signed bits.
    function automatic logic [CW-1:0] round_div(input logic signed [191:0] num,
                                                input logic signed [191:0] den,
                                                inout bit sat);
        logic [191:0] nm, dm, q, r;
        logic [191:0] lim;
        bit neg;
        neg = (num < 0) != (den < 0);
        nm = (num < 0) ? -num : num;
        dm = (den < 0) ? -den : den;
        q = nm / dm;
        r = nm % dm;
        if ((r << 1) >= dm) q = q + 1;
        lim = neg ? (192'(1) << (CW - 1)) : ((192'(1) << (CW - 1)) - 1);
        if (q > lim) begin
            q = lim;
            sat = 1'b1;
        end
        return neg ? CW'(-q) : CW'(q);
    endfunction

    function automatic t_res plane_at_query(input t_in t);
        logic signed [191:0] x0, y0, z0, x1, y1, z1, x2, y2, z2, qx, qy;
        logic signed [191:0] a0, a1, a2, ar2, gxn, gyn, zn;
        t_res res;
        bit sat;
        x0 = t.v0_x; y0 = t.v0_y; z0 = t.v0_z;
        x1 = t.v1_x; y1 = t.v1_y; z1 = t.v1_z;
        x2 = t.v2_x; y2 = t.v2_y; z2 = t.v2_z;
        qx = t.query_x; qy = t.query_y;
        sat = 1'b0;
        res = '0;
        a0 = x1 * y2 - x2 * y1;
        a1 = x2 * y0 - x0 * y2;
        a2 = x0 * y1 - x1 * y0;
        ar2 = a0 + a1 + a2;
        if (ar2 == 0) begin
            res.degenerate = 1'b1;
            return res;
        end
        gxn = (y1 - y2) * z0 + (y2 - y0) * z1 + (y0 - y1) * z2;
        gyn = (x2 - x1) * z0 + (x0 - x2) * z1 + (x1 - x0) * z2;
        zn = a0 * z0 + a1 * z1 + a2 * z2 + gxn * qx + gyn * qy;
        res.interp_z = round_div(zn, ar2, sat);
        res.grad_x = round_div(gxn <<< FRAC, ar2, sat);
        res.grad_y = round_div(gyn <<< FRAC, ar2, sat);
        res.saturated = sat;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [CW-1:0] got,
                                   input logic [CW-1:0] want);
        n_errors++;
        $display("MISMATCH word %0d %s: got %h, expected %h", n_checked, what, got, want);
    endtask

    function automatic logic [CW-1:0] pick_coord();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3, 4: return $urandom();
            default: return CW'(int'($urandom_range(16'hffff)) - 32768) <<< $urandom_range(16);
        endcase
    endfunction

    function automatic t_in random_tri();
        t_in t;
        t = {pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_coord(),
             pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_coord(),
             pick_coord()};
        // collinear or coincident vertices now and then
        if ($urandom_range(9) == 0) begin
            t.v2_x = t.v1_x;
            t.v2_y = t.v1_y;
        end else if ($urandom_range(14) == 0) begin
            t.v2_x = t.v0_x + 2 * (t.v1_x - t.v0_x);
            t.v2_y = t.v0_y + 2 * (t.v1_y - t.v0_y);
        end
        return t;
    endfunction

    // Driver: offers the head of the queue, holds it until accepted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                n_sent++;
                plane_queue.push_back(plane_at_query({i_v0_x, i_v0_y, i_v0_z, i_v1_x,
                    i_v1_y, i_v1_z, i_v2_x, i_v2_y, i_v2_z, i_query_x, i_query_y}));
                void'(tri_queue.pop_front());
            end
            if ((!i_in_valid || o_in_ready) && !sender_hold && tri_queue.size() > 0
                && !(phase == PH_SEND_IDLE && $urandom_range(99) < 24)
                && !(phase == PH_RECV_IDLE && $urandom_range(99) < 72)) begin
                i_in_valid <= 1'b1;
                {i_v0_x, i_v0_y, i_v0_z, i_v1_x, i_v1_y, i_v1_z, i_v2_x, i_v2_y,
                 i_v2_z, i_query_x, i_query_y} <= tri_queue[0];
            end else if (i_in_valid && o_in_ready) begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver with random stalls and a long hold-off on request.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (recv_hold_req && recv_hold_cnt == 0) recv_hold_cnt <= HOLD_LEN;
            else if (recv_hold_cnt > 0) recv_hold_cnt <= recv_hold_cnt - 1;
            if (recv_hold_cnt > 1 || (recv_hold_req && recv_hold_cnt == 0))
                i_out_ready <= 1'b0;
            else if (phase == PH_SEND_IDLE) i_out_ready <= $urandom_range(99) >= 72;
            else if (phase == PH_RECV_IDLE) i_out_ready <= $urandom_range(99) >= 24;
            else i_out_ready <= 1'b1;
        end
    end

    // Monitor and scoreboard.
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (plane_queue.size() == 0) begin
                n_errors++;
                $display("MISMATCH: unexpected output word");
            end else begin
                want = plane_queue.pop_front();
                if (o_interp_z !== want.interp_z)
                    report_mismatch("interp_z", o_interp_z, want.interp_z);
                if (o_grad_x !== want.grad_x)
                    report_mismatch("grad_x", o_grad_x, want.grad_x);
                if (o_grad_y !== want.grad_y)
                    report_mismatch("grad_y", o_grad_y, want.grad_y);
                if (o_degenerate !== want.degenerate)
                    report_mismatch("degenerate", CW'(o_degenerate), CW'(want.degenerate));
                if (o_saturated !== want.saturated)
                    report_mismatch("saturated", CW'(o_saturated), CW'(want.saturated));
                n_degen += want.degenerate;
                n_sat += want.saturated;
            end
            n_checked++;
        end
    end

    // Watchdog: cycles with no handshake on either side.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WDOG_MAX) begin
            $display("Timeout after %0d idle cycles", idle_cnt);
            $display("Verification failed");
            $finish;
        end
    end

    task automatic wait_sent(input int n);
        while (n_sent < n) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (plane_queue.size() > 0 || tri_queue.size() > 0 || i_in_valid)
            @(posedge i_clk);
    endtask

    initial begin
        t_in t;
        int total;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: unit triangle, extremes, degenerate, ties
        t = '0; t.v1_x = 32'h0001_0000; t.v2_y = 32'h0001_0000;
        t.v0_z = 32'h0002_0000; t.v1_z = 32'h0005_0000; t.v2_z = 32'hfffd_0000;
        t.query_x = 32'h0000_4000; t.query_y = 32'h0000_4000;
        tri_queue.push_back(t);
        tri_queue.push_back('0);
        tri_queue.push_back('1);
        t = {11{32'h7fff_ffff}}; tri_queue.push_back(t);
        t = {11{32'h8000_0000}}; tri_queue.push_back(t);
        t = '0; t.v0_x = 32'h8000_0000; t.v1_x = 32'h7fff_ffff; t.v1_y = 32'h8000_0000;
        t.v2_y = 32'h7fff_ffff; t.v0_z = 32'h7fff_ffff; t.v1_z = 32'h8000_0000;
        t.v2_z = 32'h7fff_ffff; t.query_x = 32'h8000_0000; t.query_y = 32'h7fff_ffff;
        tri_queue.push_back(t);
        t = '0; t.v1_x = 1; t.v2_y = 1; t.v1_z = 32'h7fff_ffff; t.v2_z = 32'h8000_0000;
        tri_queue.push_back(t);
        // small area, big slope: saturation
        t = '0; t.v1_x = 1; t.v2_y = 3; t.v1_z = 32'h4000_0000; t.query_x = 32'h1000;
        tri_queue.push_back(t);
        // exact half-step quotient: tie away from zero
        t = '0; t.v1_x = 2; t.v2_y = 1; t.v1_z = 1; t.query_x = 1;
        tri_queue.push_back(t);
        t.v1_z = -1; tri_queue.push_back(t);
        for (int i = 0; i < 10; i++) tri_queue.push_back(random_tri());
        total = tri_queue.size();

        // receiver stalls more than the sender idles
        for (int i = 0; i < N_RANDOM / 3; i++) tri_queue.push_back(random_tri());
        total += N_RANDOM / 3;
        wait_sent(total - 100);
        recv_hold_req <= 1'b1;    // long receiver stall fills the pipeline
        @(posedge i_clk);
        recv_hold_req <= 1'b0;
        wait_sent(total);
        sender_hold = 1'b1;       // pause until all words come back
        wait_drained();
        sender_hold = 1'b0;

        phase = PH_RECV_IDLE;
        for (int i = 0; i < N_RANDOM / 3; i++) tri_queue.push_back(random_tri());
        total += N_RANDOM / 3;
        wait_drained();

        phase = PH_NO_IDLE;
        for (int i = 0; i < N_RANDOM / 3; i++) tri_queue.push_back(random_tri());
        wait_drained();
        repeat (LATENCY + 10) @(posedge i_clk);

        $display("Ran %0d triangles: %0d degenerate, %0d saturated, with stalls on both sides.",
                 n_sent, n_degen, n_sat);
        if (n_errors == 0 && plane_queue.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches, %0d words left", n_errors, plane_queue.size());
            $display("Verification failed");
        end
        $finish;
    end
endmodule

@@ sim.f @@
hdl/tpi_pkg.sv
hdl/tpi_front.sv
hdl/tpi_div_cell.sv
hdl/tpi_round.sv
hdl/triangle_plane_interpolator.sv
verif/tb_top.sv
